// File: hw/rtl/positional_list_engine_macros.svh
// Assertion macros used by the list engine RTL.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

`define PLE_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

`define PLE_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`else

`define PLE_ASSERT_IMP(lbl, a, c, msg)

`define PLE_ASSERT_NXT(lbl, a, c, msg)

`endif

`endif

// File: hw/rtl/ple_pkg.sv
`default_nettype none

package ple_pkg;

    localparam int PLE_CAPACITY   = 32;
    localparam int PLE_DATA_WIDTH = 32;
    // Slot index width that covers the largest supported capacity.
    localparam int PLE_IDX_W      = 6;
    localparam int PLE_ITEM_W     = 32;
    localparam int PLE_TOTAL_W    = 6;

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_RESULT = 2'd1,
        ST_DUMP   = 2'd2
    } state_t;

    typedef struct packed {
        cell_op_t               op;
        logic [PLE_IDX_W-1:0]   slot;
        logic [PLE_IDX_W-1:0]   last;
    } chain_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/ple_cell.sv
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int DATA_WIDTH = PLE_DATA_WIDTH,
    parameter int INDEX      = 0
)
(
    input  wire logic                  clk,
    input  wire chain_ctrl_t           ctrl,
    input  wire logic [DATA_WIDTH-1:0] new_value,
    input  wire logic [DATA_WIDTH-1:0] left_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic [DATA_WIDTH-1:0] head_data,
    output logic      [DATA_WIDTH-1:0] data
);

    localparam logic [PLE_IDX_W-1:0] MY_IDX = PLE_IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                // Cells past the slot take their left neighbor, opening a gap.
                if (MY_IDX > ctrl.slot)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == ctrl.slot)
                begin
                    data_next = new_value;
                end
            end
            OP_DELETE:
            begin
                if (MY_IDX >= ctrl.slot)
                begin
                    data_next = right_data;
                end
            end
            OP_ROTATE:
            begin
                // The occupied part of the row turns by one toward the head.
                if (MY_IDX < ctrl.last)
                begin
                    data_next = right_data;
                end
                else if (MY_IDX == ctrl.last)
                begin
                    data_next = head_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ple_chain.sv
`default_nettype none

module ple_chain
    import ple_pkg::*;
#(
    parameter int CAPACITY   = PLE_CAPACITY,
    parameter int DATA_WIDTH = PLE_DATA_WIDTH
)
(
    input  wire logic                  clk,
    input  wire chain_ctrl_t           ctrl,
    input  wire logic [DATA_WIDTH-1:0] new_value,
    output logic      [DATA_WIDTH-1:0] head_data
);

    logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
    logic [DATA_WIDTH-1:0] left_wire  [CAPACITY];
    logic [DATA_WIDTH-1:0] right_wire [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left_wire[g] = new_value;
        end
        else
        begin : g_inner_left
            assign left_wire[g] = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_wire[g] = cell_data[g];
        end
        else
        begin : g_inner_right
            assign right_wire[g] = cell_data[g+1];
        end

        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_value  (new_value),
            .left_data  (left_wire[g]),
            .right_data (right_wire[g]),
            .head_data  (cell_data[0]),
            .data       (cell_data[g])
        );
    end

    assign head_data = cell_data[0];

endmodule

`default_nettype wire

// File: hw/rtl/positional_list_engine.sv
//  Channel  Direction  Handshake            Payload
//  in       to block   in_valid / in_stall   cmd, value, position
//  out      from block out_valid / out_stall status, item_value, has_value,
//                                            element_total, last_item
//
//  Insert and delete shift the whole row of cells in a single register update,
//  and such an item's single result appears the next cycle after it is taken.
//  A dump turns the row by one cell per result taken, giving one result per
//  element, and the row is back in order after the last one.
//  One item is in work at a time; in_stall is high while any result is pending.
//  Reset empties the list at once; element contents are not cleared.
//  A stall on the output holds the pending result and the dump position.
`default_nettype none

`include "positional_list_engine_macros.svh"

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY   = PLE_CAPACITY,
    parameter int DATA_WIDTH = PLE_DATA_WIDTH
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [2:0]                    cmd,
    input  wire logic signed [31:0]            value,
    input  wire logic [15:0]                   position,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         status,
    output logic signed [PLE_ITEM_W-1:0]       item_value,
    output logic                               has_value,
    output logic [PLE_TOTAL_W-1:0]             element_total,
    output logic                               last_item
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CNT_W-1:0]     remain_reg;
    logic [CNT_W-1:0]     remain_next;
    status_t              status_reg;
    status_t              status_next;

    chain_ctrl_t          ctrl;
    logic [DATA_WIDTH-1:0] store_value;
    logic [DATA_WIDTH-1:0] head_data;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 ins_pos_ok;
    logic                 del_pos_ok;
    logic [16:0]          pos_ext;
    logic [16:0]          cnt_ext;

    // Signed size cast sign-extends or truncates the value to the cell width.
    assign store_value = DATA_WIDTH'(value);

    assign accept     = (state_reg == ST_IDLE) && in_valid;
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign pos_ext    = {1'b0, position};
    assign cnt_ext    = 17'(count_reg);
    assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + 17'd1);
    assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);

    ple_chain #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .new_value  (store_value),
        .head_data  (head_data)
    );

    // Command decode and chain control.
    always_comb
    begin
        ctrl.op     = OP_HOLD;
        ctrl.slot   = '0;
        ctrl.last   = '0;
        count_next  = count_reg;
        status_next = status_reg;
        remain_next = remain_reg;

        if (accept)
        begin
            status_next = STAT_OK;
            case (cmd_t'(cmd)) inside
                CMD_INS_FRONT, CMD_INS_BACK:
                begin
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ctrl.op    = OP_INSERT;
                        ctrl.slot  = (cmd_t'(cmd) == CMD_INS_FRONT) ? '0
                                                                    : PLE_IDX_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_INS_AT:
                begin
                    if (!ins_pos_ok)
                    begin
                        status_next = STAT_BADPOS;
                    end
                    else if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ctrl.op    = OP_INSERT;
                        ctrl.slot  = PLE_IDX_W'(position - 16'd1);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_DEL_FRONT, CMD_DEL_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        ctrl.op    = OP_DELETE;
                        ctrl.slot  = (cmd_t'(cmd) == CMD_DEL_FRONT)
                                     ? '0 : PLE_IDX_W'(count_reg - CNT_W'(1));
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_DEL_AT:
                begin
                    if (empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else if (!del_pos_ok)
                    begin
                        status_next = STAT_BADPOS;
                    end
                    else
                    begin
                        ctrl.op    = OP_DELETE;
                        ctrl.slot  = PLE_IDX_W'(position - 16'd1);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                CMD_DUMP:
                begin
                    remain_next = count_reg;
                end
                default:
                begin
                    status_next = STAT_BADPOS;
                end
            endcase
        end
        else if ((state_reg == ST_DUMP) && !out_stall)
        begin
            ctrl.op     = OP_ROTATE;
            ctrl.last   = PLE_IDX_W'(count_reg - CNT_W'(1));
            remain_next = remain_reg - CNT_W'(1);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if ((cmd_t'(cmd) == CMD_DUMP) && !empty)
                    begin
                        state_next = ST_DUMP;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DUMP:
            begin
                if (!out_stall && (remain_reg == CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_stall      = (state_reg != ST_IDLE);
        out_valid     = 1'b0;
        status        = STAT_OK;
        item_value    = '0;
        has_value     = 1'b0;
        last_item     = 1'b0;
        element_total = PLE_TOTAL_W'(count_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                out_valid = 1'b0;
            end
            ST_RESULT:
            begin
                out_valid = 1'b1;
                status    = status_reg;
                last_item = 1'b1;
            end
            ST_DUMP:
            begin
                out_valid  = 1'b1;
                item_value = PLE_ITEM_W'(head_data);
                has_value  = 1'b1;
                last_item  = (remain_reg == CNT_W'(1));
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            status_reg <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            status_reg <= status_next;
        end
    end

    `PLE_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `PLE_ASSERT_IMP(a_one_in_flight, out_valid, in_stall, "input taken while result pending")
    `PLE_ASSERT_NXT(a_count_stable, !(in_valid && !in_stall), $stable(count_reg), "count moved without an input item")
    `PLE_ASSERT_IMP(a_dump_nonzero, state_reg == ST_DUMP, remain_reg != '0 && !empty, "dump with nothing left")
    `PLE_ASSERT_NXT(a_dump_hold, out_valid && out_stall && state_reg == ST_DUMP, $stable(item_value), "dump item changed under stall")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
    import ple_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Code 7 has no command behind it and must be answered as a bad position.
    localparam logic [2:0] CMD_UNKNOWN = 3'd7;
    localparam int TAIL_ITEMS = 25;
    localparam int RANDOM_ITEMS = 100;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] value;
        logic [15:0] position;
    } list_cmd_t;

    typedef struct packed {
        status_t                status;
        logic [31:0]            item_value;
        logic                   has_value;
        logic [PLE_TOTAL_W-1:0] total;
        logic                   last;
    } list_result_t;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } mix_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [2:0]             cmd = 3'd0;
    logic signed [31:0]     value = 32'sd0;
    logic [15:0]            position = 16'd0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             status;
    logic signed [31:0]     item_value;
    logic                   has_value;
    logic [PLE_TOTAL_W-1:0] element_total;
    logic                   last_item;

    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];
    logic [31:0]  list_vals[$];
    list_cmd_t    in_flight;

    int  plan_count = 0;
    int  random_queued = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    logic quiet_tail = 1'b0;

    int  commands_applied = 0;
    int  results_checked = 0;
    int  mismatch_count = 0;
    int  dump_count = 0;
    int  deepest_fill = 0;
    int  status_seen[4] = '{0, 0, 0, 0};

    positional_list_engine u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .position     (position),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .item_value   (item_value),
        .has_value    (has_value),
        .element_total(element_total),
        .last_item    (last_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Outcome of a command on a list holding n entries; inserts check the
    // position before the room left.
    function automatic status_t cmd_status(int n, logic [2:0] c, logic [15:0] p);
        case (c)
            CMD_INS_FRONT, CMD_INS_BACK:
                return (n >= PLE_CAPACITY) ? STAT_FULL : STAT_OK;
            CMD_INS_AT:
            begin
                if (p < 1 || p > n + 1)
                    return STAT_BADPOS;
                return (n >= PLE_CAPACITY) ? STAT_FULL : STAT_OK;
            end
            CMD_DEL_FRONT, CMD_DEL_BACK:
                return (n == 0) ? STAT_EMPTY : STAT_OK;
            CMD_DEL_AT:
            begin
                if (n == 0)
                    return STAT_EMPTY;
                return (p < 1 || p > n) ? STAT_BADPOS : STAT_OK;
            end
            CMD_DUMP:
                return STAT_OK;
            default:
                return STAT_BADPOS;
        endcase
    endfunction

    // Queues a command and keeps track of the list size it will leave behind.
    function automatic void queue_command(list_cmd_t it);
        if (cmd_status(plan_count, it.cmd, it.position) == STAT_OK)
        begin
            if (it.cmd == CMD_INS_FRONT || it.cmd == CMD_INS_BACK || it.cmd == CMD_INS_AT)
                plan_count++;
            else if (it.cmd == CMD_DEL_FRONT || it.cmd == CMD_DEL_BACK ||
                     it.cmd == CMD_DEL_AT)
                plan_count--;
        end
        pending_cmds.push_back(it);
    endfunction

    function automatic list_cmd_t random_item(mix_t mix);
        list_cmd_t it;
        int ins_pct;
        int del_pct;
        int r;
        ins_pct = (mix == MIX_GROW) ? 80 : (mix == MIX_SHRINK) ? 10 : 45;
        del_pct = (mix == MIX_GROW) ? 12 : (mix == MIX_SHRINK) ? 82 : 40;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            it.cmd = 3'($urandom_range(CMD_INS_FRONT, CMD_INS_AT));
        else if (r < ins_pct + del_pct)
            it.cmd = 3'($urandom_range(CMD_DEL_FRONT, CMD_DEL_AT));
        else if (r < 97)
            it.cmd = CMD_DUMP;
        else
            it.cmd = CMD_UNKNOWN;

        case ($urandom_range(0, 9))
            0: it.value = 32'h7FFF_FFFF;
            1: it.value = 32'h8000_0000;
            2: it.value = 32'h0000_0000;
            3: it.value = 32'hFFFF_FFFF;
            default: it.value = $urandom;
        endcase

        // Mostly legal positions, with some just past either end and some wild.
        r = $urandom_range(0, 99);
        if (it.cmd == CMD_INS_AT && r < 85)
            it.position = 16'($urandom_range(1, plan_count + 1));
        else if (it.cmd == CMD_DEL_AT && r < 85)
            it.position = 16'($urandom_range(1, (plan_count > 0) ? plan_count : 1));
        else if (r < 90)
            it.position = 16'(plan_count + $urandom_range(1, 2));
        else if (r < 94)
            it.position = 16'd0;
        else if (r < 96)
            it.position = 16'hFFFF;
        else
            it.position = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    task automatic predict_results(list_cmd_t it);
        status_t st;
        int n;
        st = cmd_status(list_vals.size(), it.cmd, it.position);
        if (it.cmd == CMD_DUMP)
        begin
            n = list_vals.size();
            dump_count++;
            if (n == 0)
                expected_results.push_back('{STAT_OK, 32'd0, 1'b0, '0, 1'b1});
            for (int i = 0; i < n; i++)
                expected_results.push_back('{STAT_OK, list_vals[i], 1'b1,
                                             PLE_TOTAL_W'(n), (i == n - 1)});
        end
        else
        begin
            if (st == STAT_OK)
            begin
                case (it.cmd)
                    CMD_INS_FRONT: list_vals.push_front(it.value);
                    CMD_INS_BACK:  list_vals.push_back(it.value);
                    CMD_INS_AT:    list_vals.insert(it.position - 1, it.value);
                    CMD_DEL_FRONT: list_vals.delete(0);
                    CMD_DEL_BACK:  list_vals.delete(list_vals.size() - 1);
                    CMD_DEL_AT:    list_vals.delete(it.position - 1);
                    default:       ;
                endcase
            end
            if (list_vals.size() > deepest_fill)
                deepest_fill = list_vals.size();
            expected_results.push_back('{st, 32'd0, 1'b0,
                                         PLE_TOTAL_W'(list_vals.size()), 1'b1});
        end
    endtask

    task automatic check_result();
        list_result_t got;
        list_result_t want;
        got = '{status_t'(status), item_value, has_value, element_total, last_item};
        results_checked++;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_MISMATCHES)
            begin
                $write("%0t: result with nothing expected:", $realtime);
                $display(" status %0d value %h has %b total %0d last %b",
                         got.status, got.item_value, got.has_value, got.total,
                         got.last);
            end
        end
        else
        begin
            want = expected_results.pop_front();
            status_seen[want.status]++;
            if (got !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_MISMATCHES)
                begin
                    $write("%0t: mismatch: expected status %0d value %h has %b",
                           $realtime, want.status, want.item_value, want.has_value);
                    $write(" total %0d last %b,", want.total, want.last);
                    $display(" got status %0d value %h has %b total %0d last %b",
                             got.status, got.item_value, got.has_value, got.total,
                             got.last);
                end
            end
        end
    endtask

    // Command driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            quiet_tail <= (pending_cmds.size() < TAIL_ITEMS);
            if (in_valid && !in_stall)
            begin
                predict_results(in_flight);
                commands_applied++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 11) == 0)
                begin
                    send_gap = $urandom_range(0, 18);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_flight = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    cmd <= in_flight.cmd;
                    value <= in_flight.value;
                    position <= in_flight.position;
                end
            end
        end
    end

    // Result monitor and output back-pressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        mix_t mix;

        // Empty list: dump and every kind of delete, then bad insert positions.
        queue_command('{CMD_DUMP, 32'd0, 16'd0});
        queue_command('{CMD_DEL_FRONT, 32'd0, 16'd1});
        queue_command('{CMD_DEL_BACK, 32'd0, 16'd1});
        queue_command('{CMD_DEL_AT, 32'd0, 16'd1});
        queue_command('{CMD_DEL_AT, 32'd0, 16'd0});
        queue_command('{CMD_INS_AT, 32'h1234_5678, 16'd0});
        queue_command('{CMD_INS_AT, 32'h1234_5678, 16'd2});
        // Build a short list from both ends and the middle with extreme values.
        queue_command('{CMD_INS_FRONT, 32'h7FFF_FFFF, 16'hFFFF});
        queue_command('{CMD_INS_BACK, 32'h8000_0000, 16'd0});
        queue_command('{CMD_INS_AT, 32'h0000_0000, 16'd1});
        queue_command('{CMD_INS_AT, 32'hFFFF_FFFF, 16'd4});
        queue_command('{CMD_INS_AT, 32'h5555_AAAA, 16'd3});
        queue_command('{CMD_INS_AT, 32'hAAAA_5555, 16'hFFFF});
        queue_command('{CMD_DUMP, 32'hFFFF_FFFF, 16'hFFFF});
        queue_command('{CMD_DEL_AT, 32'd0, 16'd0});
        queue_command('{CMD_DEL_AT, 32'd0, 16'd6});
        queue_command('{CMD_DEL_AT, 32'd0, 16'hFFFF});
        queue_command('{CMD_DEL_AT, 32'd0, 16'd3});
        queue_command('{CMD_DEL_FRONT, 32'd0, 16'd0});
        queue_command('{CMD_DEL_BACK, 32'd0, 16'd0});
        queue_command('{CMD_UNKNOWN, 32'hDEAD_BEEF, 16'd1});
        queue_command('{CMD_DUMP, 32'd0, 16'd0});

        // Fill to capacity, hit the full limit every way, read it all back.
        while (plan_count < PLE_CAPACITY)
        begin
            queue_command(random_item(MIX_GROW));
            random_queued++;
        end
        queue_command('{CMD_INS_FRONT, 32'h0BAD_F00D, 16'd1});
        queue_command('{CMD_INS_BACK, 32'h0BAD_F00D, 16'd1});
        queue_command('{CMD_INS_AT, 32'h0BAD_F00D, 16'(PLE_CAPACITY)});
        queue_command('{CMD_INS_AT, 32'h0BAD_F00D, 16'(PLE_CAPACITY + 2)});
        queue_command('{CMD_INS_AT, 32'h0BAD_F00D, 16'd0});
        queue_command('{CMD_DUMP, 32'd0, 16'd0});
        random_queued += 6;

        // Drain to empty, then run at least one mixed stretch.
        while (plan_count > 0)
        begin
            queue_command(random_item(MIX_SHRINK));
            random_queued++;
        end
        queue_command(random_item(MIX_SHRINK));
        random_queued++;
        do
        begin
            mix = mix_t'($urandom_range(MIX_GROW, MIX_BALANCED));
            for (int k = 0; k < 15; k++)
                queue_command(random_item(mix));
            random_queued += 15;
        end
        while (random_queued < RANDOM_ITEMS);
        queue_command('{CMD_DUMP, 32'd0, 16'd0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Applied %0d commands (%0d dumps), checked %0d results;",
                 commands_applied, dump_count, results_checked);
        $display("list reached %0d of %0d entries. Status mix: ok %0d, bad position %0d,",
                 deepest_fill, PLE_CAPACITY, status_seen[STAT_OK],
                 status_seen[STAT_BADPOS]);
        $display("full %0d, empty %0d.", status_seen[STAT_FULL], status_seen[STAT_EMPTY]);
        if (mismatch_count == 0)
            $display("positional_list_engine test passed");
        else
            $display("positional_list_engine test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d commands queued and %0d results outstanding.",
                 pending_cmds.size(), expected_results.size());
        $display("positional_list_engine test failed");
        $finish;
    end

endmodule

`default_nettype wire
